/* hdl/uqp_pkg.sv */
// Shared constants, command and status codes, sequencer state and control types
// for the unsorted max-priority queue. No dependencies.
package uqp_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);

   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_TOP  = 2'd1;
   localparam logic [1:0] CMD_POP  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_SWAP_A,
      S_SWAP_B,
      S_FRONT_RD,
      S_SHIFT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic             load;
      logic             step;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

endpackage

/* hdl/unsorted_max_priority_queue.sv */
// Unsorted max-priority queue, top level: request/response handshake, sequencer, store.
// Push appends at the back; top/pop with a cached top reads the front entry, else it scans
// all entries and swaps the winner to the front; a pop then shifts the entries down one place.
// Throughput: one request at a time; the single RAM port pair and one comparator set it.
// Reset (synchronous, active high) empties the queue and clears the cached-top mark;
// the entry store itself is not cleared, unwritten entries are never read.
module unsorted_max_priority_queue
   import uqp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_cmd,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_top_value,
   output logic [1:0]               rsp_status
);

   // Sequencer state and control registers
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             fim_ff, fim_in;      // front entry holds the maximum
   logic [CNT_W-1:0] ptr_ff, ptr_in;      // next RAM address to read

   // Request capture and result hold
   logic [1:0]        cmd_ff, cmd_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic [1:0]        st_ff, st_in;

   // Output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_top_value_ff, rsp_top_value_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   // RAM and scan unit hookup
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   scan_ctl_type      scan_ctl;
   logic signed [DATA_W-1:0] best_val;
   logic [IDX_W-1:0]  best_idx;
   logic [DATA_W-1:0] front_val;

   logic              req_accept;
   logic              rsp_load;
   logic              is_topop;
   logic              at_end;
   logic [CNT_W-1:0]  ptr_m1;
   logic [CNT_W-1:0]  ptr_m2;

   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign is_topop   = (cmd_ff == CMD_TOP) || (cmd_ff == CMD_POP);
   assign at_end     = (ptr_ff == count_ff);
   assign ptr_m1     = ptr_ff - CNT_W'(1);
   assign ptr_m2     = ptr_ff - CNT_W'(2);

   uqp_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   uqp_scan_unit u_scan (
      .clock     (clock),
      .ctl       (scan_ctl),
      .rd_data   (rd_data),
      .best_val  (best_val),
      .best_idx  (best_idx),
      .front_val (front_val)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (is_topop && (count_ff != '0)) begin
               state_in = fim_ff ? S_FRONT_RD : S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (at_end) state_in = S_SWAP_A;
         end
         S_SWAP_A: begin
            state_in = S_SWAP_B;
         end
         S_SWAP_B, S_FRONT_RD: begin
            state_in = (cmd_ff == CMD_POP) ? S_SHIFT : S_DONE;
         end
         S_SHIFT: begin
            if (at_end) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath control
   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      scan_ctl      = '0;
      count_in      = count_ff;
      fim_in        = fim_ff;
      ptr_in        = ptr_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      res_in        = res_ff;
      st_in         = st_ff;
      unique case (state_ff)
         S_IDLE: begin
            // capture the request
            if (req_accept) begin
               cmd_in   = req_cmd;
               value_in = req_value;
            end
         end
         S_DECIDE: begin
            res_in = '0;
            st_in  = ST_OK;
            if (cmd_ff == CMD_PUSH) begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  // full: drop the value, leave state alone
                  st_in = ST_FULL;
               end else begin
                  // append at the back; the cached top may now be stale
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  wr_data  = value_ff;
                  count_in = count_ff + CNT_W'(1);
                  fim_in   = 1'b0;
               end
            end else if (is_topop) begin
               if (count_ff == '0) begin
                  st_in = ST_EMPTY;
               end else begin
                  // fetch the front entry for either path
                  rd_en   = 1'b1;
                  rd_addr = '0;
                  ptr_in  = CNT_W'(1);
               end
            end
         end
         S_SCAN: begin
            // data in hand is entry ptr-1; load on the front entry, compare after
            scan_ctl.idx = ptr_m1[IDX_W-1:0];
            if (ptr_ff == CNT_W'(1)) begin
               scan_ctl.load = 1'b1;
            end else begin
               scan_ctl.step = 1'b1;
            end
            if (!at_end) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_ff + CNT_W'(1);
            end
         end
         S_SWAP_A: begin
            // winner to the front
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = best_val;
            res_in  = best_val;
            fim_in  = 1'b1;
         end
         S_SWAP_B: begin
            // old front into the winner's slot
            wr_en   = 1'b1;
            wr_addr = best_idx;
            wr_data = front_val;
            ptr_in  = CNT_W'(1);
         end
         S_FRONT_RD: begin
            // cached top: front entry is the answer
            res_in = rd_data;
            ptr_in = CNT_W'(1);
         end
         S_SHIFT: begin
            // move entry ptr-1 down one place while reading the next
            if (ptr_ff != CNT_W'(1)) begin
               wr_en   = 1'b1;
               wr_addr = ptr_m2[IDX_W-1:0];
               wr_data = rd_data;
            end
            if (!at_end) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_ff + CNT_W'(1);
            end else begin
               count_in = count_ff - CNT_W'(1);
               fim_in   = 1'b0;
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Output register: load when the slot is free, drop on a taken response
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_top_value_in = rsp_top_value_ff;
      rsp_status_in    = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in     = 1'b1;
         rsp_top_value_in = $signed(res_ff);
         rsp_status_in    = st_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         fim_ff       <= 1'b0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fim_ff       <= fim_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff           <= cmd_in;
      value_ff         <= value_in;
      res_ff           <= res_in;
      st_ff            <= st_in;
      rsp_top_value_ff <= rsp_top_value_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

/* hdl/uqp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uqp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/uqp_scan_unit.sv */
// Shared signed comparator with best-value/best-index registers for the max scan.
// Depends on uqp_pkg.
module uqp_scan_unit
   import uqp_pkg::*;
(
   input  logic                     clock,
   input  scan_ctl_type             ctl,
   input  logic [DATA_W-1:0]        rd_data,
   output logic signed [DATA_W-1:0] best_val,
   output logic [IDX_W-1:0]         best_idx,
   output logic [DATA_W-1:0]        front_val
);

   logic signed [DATA_W-1:0] best_val_ff;
   logic signed [DATA_W-1:0] best_val_in;
   logic [IDX_W-1:0]         best_idx_ff;
   logic [IDX_W-1:0]         best_idx_in;
   logic [DATA_W-1:0]        front_val_ff;
   logic [DATA_W-1:0]        front_val_in;
   logic                     larger;

   // Strictly larger only: earliest of equal maxima wins.
   assign larger = $signed(rd_data) > best_val_ff;

   always_comb begin
      best_val_in  = best_val_ff;
      best_idx_in  = best_idx_ff;
      front_val_in = front_val_ff;
      if (ctl.load) begin
         best_val_in  = $signed(rd_data);
         best_idx_in  = ctl.idx;
         front_val_in = rd_data;
      end else if (ctl.step && larger) begin
         best_val_in = $signed(rd_data);
         best_idx_in = ctl.idx;
      end
   end

   always_ff @(posedge clock) begin
      best_val_ff  <= best_val_in;
      best_idx_ff  <= best_idx_in;
      front_val_ff <= front_val_in;
   end

   assign best_val  = best_val_ff;
   assign best_idx  = best_idx_ff;
   assign front_val = front_val_ff;

endmodule
